### design/hell_dot_energy_slicer_top_assert.svh
// Assertion macros used by the dot slicer core module.
`ifndef HELL_DOT_ENERGY_SLICER_TOP_ASSERT_SVH
`define HELL_DOT_ENERGY_SLICER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define HDES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define HDES_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define HDES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/hdes_pkg.sv
// Types and constants of the dot energy slicer.
package hdes_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SQ_W       = 31;
  localparam int unsigned SPD_W      = 24;
  localparam int unsigned THR_W      = 32;
  localparam int unsigned ENERGY_W   = 47;
  localparam int unsigned TALLY_W    = 16;
  localparam int unsigned PROD_W     = THR_W + TALLY_W;
  localparam int unsigned COLCNT_W   = 32;
  localparam int unsigned BX_W       = 10;
  localparam int unsigned BY_W       = 8;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [SPD_W-1:0] SAMPLE_STEP   = SPD_W'(256);
  localparam logic [SPD_W-1:0] SPD_RESET     = SPD_W'(100310);
  localparam logic [THR_W-1:0] THR_RESET     = THR_W'(1717987);
  localparam logic [BX_W-1:0]  X_ORIGIN      = BX_W'(20);
  localparam logic [BY_W-1:0]  Y_ORIGIN      = BY_W'(50);
  localparam int unsigned      ROW_PITCH_LG2 = 3;

  typedef enum logic {
    REG_SAMPLES_PER_DOT = 1'b0,
    REG_THRESHOLD       = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [SPD_W-1:0] samples_per_dot;
    logic [THR_W-1:0] threshold_energy;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [SQ_W-1:0] sq;
  } sq_stage_t;

endpackage

### design/hdes_if.sv
// Sample and dot result channel interfaces.
interface hdes_in_if;
  import hdes_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface hdes_out_if;
  import hdes_pkg::*;

  logic                valid;
  logic                ready;
  logic                dot_on;
  logic [BX_W-1:0]     block_x;
  logic [BY_W-1:0]     block_y;
  logic                line_ready;
  logic [COLCNT_W-1:0] column_count;

  modport source (output valid, output dot_on, output block_x, output block_y,
                  output line_ready, output column_count, input ready);
  modport sink   (input valid, input dot_on, input block_x, input block_y,
                  input line_ready, input column_count, output ready);
endinterface

### design/hdes_cfg.sv
// APB register file for dot period and energy threshold.
module hdes_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hdes_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [hdes_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [hdes_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output hdes_pkg::cfg_t                   cfg_q_o,
  output hdes_pkg::cfg_t                   cfg_d_o
);
  import hdes_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_SAMPLES_PER_DOT: cfg_d.samples_per_dot  = pwdata[SPD_W-1:0];
        REG_THRESHOLD:       cfg_d.threshold_energy = pwdata[THR_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SAMPLES_PER_DOT: prdata = APB_DATA_W'(cfg_q.samples_per_dot);
      REG_THRESHOLD:       prdata = APB_DATA_W'(cfg_q.threshold_energy);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.samples_per_dot  <= SPD_RESET;
      cfg_q.threshold_energy <= THR_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_q_o = cfg_q;
  assign cfg_d_o = cfg_d;

endmodule

### design/hdes_square.sv
// Input stage: register each sample's square.
module hdes_square (
  input  logic                clk_i,
  input  logic                rst_ni,
  hdes_in_if.sink             in_i,
  input  logic                free_i,
  output hdes_pkg::sq_stage_t stage_o
);
  import hdes_pkg::*;

  logic                  valid_q, valid_d;
  logic [SQ_W-1:0]       sq_q;
  logic signed [31:0]    sq_full;
  logic                  accept;

  // Downstream takes the held square whenever the result side is free.
  assign in_i.ready = ~valid_q | free_i;
  assign accept     = in_i.valid & in_i.ready;
  assign sq_full    = in_i.sample * in_i.sample;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (free_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q <= sq_full[SQ_W-1:0];
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.sq    = sq_q;

endmodule

### design/hdes_core.sv
// Energy accumulation, dot decision, raster counters and result register.
module hdes_core #(
  parameter int unsigned ROWS_PER_COLUMN = 14,
  parameter int unsigned CANVAS_COLUMNS  = 600,
  parameter int unsigned LINE_EVERY      = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hdes_pkg::sq_stage_t stage_i,
  input  hdes_pkg::cfg_t      cfg_q_i,
  input  hdes_pkg::cfg_t      cfg_d_i,
  output logic                free_o,
  hdes_out_if.source          out_o
);
  import hdes_pkg::*;
  `include "hell_dot_energy_slicer_top_assert.svh"

  localparam int unsigned RW = $clog2(ROWS_PER_COLUMN);
  localparam int unsigned CW = $clog2(CANVAS_COLUMNS);
  localparam int unsigned LW = (LINE_EVERY > 1) ? $clog2(LINE_EVERY) : 1;
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS_PER_COLUMN - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(CANVAS_COLUMNS - 1);
  localparam logic [LW-1:0] LINE_LAST = LW'(LINE_EVERY - 1);

  logic [SPD_W-1:0]    timer_q, timer_d;
  logic [ENERGY_W-1:0] energy_q, energy_d;
  logic [TALLY_W-1:0]  tally_q, tally_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [RW-1:0]       row_q, row_d;
  logic [COLCNT_W-1:0] col_total_q, col_total_d;
  logic [CW-1:0]       col_mod_q, col_mod_d;
  logic [LW-1:0]       line_mod_q, line_mod_d;

  logic                out_valid_q, out_valid_d;
  logic                dot_on_q, line_ready_q;
  logic [BX_W-1:0]     block_x_q;
  logic [BY_W-1:0]     block_y_q;
  logic [COLCNT_W-1:0] column_count_q;

  logic                take, fire, dot_on, row_wrap, line_hit;
  logic                tally_full;
  logic [TALLY_W-1:0]  tally_inc, tally_upd;
  logic [ENERGY_W:0]   energy_sum;
  logic [ENERGY_W-1:0] energy_sat;
  logic [SPD_W:0]      timer_step;
  logic [PROD_W:0]     need;
  logic [BX_W-1:0]     block_x;
  logic [BY_W-1:0]     block_y;

  assign free_o = ~out_valid_q | out_o.ready;
  assign take   = stage_i.valid & free_o;

  // Energy with saturation at the top of the accumulator.
  assign energy_sum = {1'b0, energy_q} + (ENERGY_W + 1)'(stage_i.sq);
  assign energy_sat = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];

  assign tally_full = &tally_q;
  assign tally_inc  = tally_full ? tally_q : tally_q + TALLY_W'(1);
  assign tally_upd  = take ? tally_inc : tally_q;

  // Dot timer in Q16.8: one sample advances it by one whole step.
  assign timer_step = {1'b0, timer_q} + {1'b0, SAMPLE_STEP};
  assign fire       = timer_step >= {1'b0, cfg_q_i.samples_per_dot};

  // prod_q tracks threshold * tally; the updated tally adds one threshold.
  assign need   = tally_full ? {1'b0, prod_q}
                             : {1'b0, prod_q} + (PROD_W + 1)'(cfg_q_i.threshold_energy);
  assign dot_on = (PROD_W + 1)'(energy_sat) > need;

  assign row_wrap = (row_q == ROW_LAST);
  assign line_hit = row_wrap & (line_mod_q == LINE_LAST);
  assign block_x  = BX_W'(col_mod_q) + X_ORIGIN;
  assign block_y  = (BY_W'(row_q) << ROW_PITCH_LG2) + Y_ORIGIN;

  always_comb begin
    timer_d     = timer_q;
    energy_d    = energy_q;
    tally_d     = tally_upd;
    prod_d      = PROD_W'(cfg_d_i.threshold_energy) * PROD_W'(tally_upd);
    row_d       = row_q;
    col_total_d = col_total_q;
    col_mod_d   = col_mod_q;
    line_mod_d  = line_mod_q;
    if (take) begin
      energy_d = energy_sat;
      if (fire) begin
        timer_d  = SPD_W'(timer_step - {1'b0, cfg_q_i.samples_per_dot});
        energy_d = '0;
        tally_d  = '0;
        prod_d   = '0;
        row_d    = row_wrap ? '0 : row_q + RW'(1);
        if (row_wrap) begin
          col_total_d = col_total_q + COLCNT_W'(1);
          col_mod_d   = (col_mod_q == COL_LAST) ? '0 : col_mod_q + CW'(1);
          line_mod_d  = (line_mod_q == LINE_LAST) ? '0 : line_mod_q + LW'(1);
        end
      end else begin
        timer_d = timer_step[SPD_W-1:0];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take && fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q     <= '0;
      energy_q    <= '0;
      tally_q     <= '0;
      prod_q      <= '0;
      row_q       <= '0;
      col_total_q <= '0;
      col_mod_q   <= '0;
      line_mod_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      timer_q     <= timer_d;
      energy_q    <= energy_d;
      tally_q     <= tally_d;
      prod_q      <= prod_d;
      row_q       <= row_d;
      col_total_q <= col_total_d;
      col_mod_q   <= col_mod_d;
      line_mod_q  <= line_mod_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && fire) begin
      dot_on_q       <= dot_on;
      block_x_q      <= block_x;
      block_y_q      <= block_y;
      line_ready_q   <= line_hit;
      column_count_q <= col_total_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.dot_on       = dot_on_q;
  assign out_o.block_x      = block_x_q;
  assign out_o.block_y      = block_y_q;
  assign out_o.line_ready   = line_ready_q;
  assign out_o.column_count = column_count_q;

  `HDES_ASSERT(a_row_range, row_q <= ROW_LAST, "row index beyond column height")
  `HDES_ASSERT(a_col_range, col_mod_q <= COL_LAST, "column index beyond canvas")
  `HDES_ASSERT(a_prod_track, prod_q == PROD_W'(cfg_q_i.threshold_energy) * PROD_W'(tally_q), "product out of step")
  `HDES_ASSERT_NEXT(a_line_last_row, take && fire && line_hit, out_o.line_ready && out_o.block_y == BY_W'((BY_W'(ROW_LAST) << ROW_PITCH_LG2) + Y_ORIGIN), "line flag off last row")

endmodule

### design/hell_dot_energy_slicer_top.sv
// A sample that ends a dot passes the squarer register and then the output register.
// Throughput: one sample per cycle while the output is not stalled; the squarer register
//   and the single accumulate-and-decide stage each take one sample per clock unless stalled.
// Results wait in an output register; input stalls only while that register is full.
// Reset (async, active low) clears timer, energy, tally, raster counters and
//   loads the default dot period and threshold.
module hell_dot_energy_slicer_top #(
  parameter int unsigned ROWS_PER_COLUMN = 14,
  parameter int unsigned CANVAS_COLUMNS  = 600,
  parameter int unsigned LINE_EVERY      = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  hdes_in_if.sink                         in_i,
  hdes_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hdes_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hdes_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hdes_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import hdes_pkg::*;

  cfg_t      cfg_q, cfg_d;
  sq_stage_t sq_stage;
  logic      free;

  // Register file: cfg_d carries a write in flight so the threshold product
  // in the core tracks the new value from the next edge on.
  hdes_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_q_o (cfg_q),
    .cfg_d_o (cfg_d)
  );

  // Square each sample into a register; the multiply stays off the
  // accumulate path.
  hdes_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .free_i  (free),
    .stage_o (sq_stage)
  );

  // Accumulate energy, advance the dot timer, decide the dot and step the raster.
  hdes_core #(
    .ROWS_PER_COLUMN (ROWS_PER_COLUMN),
    .CANVAS_COLUMNS  (CANVAS_COLUMNS),
    .LINE_EVERY      (LINE_EVERY)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (sq_stage),
    .cfg_q_i (cfg_q),
    .cfg_d_i (cfg_d),
    .free_o  (free),
    .out_o   (out_o)
  );

endmodule
